// ----- rtl/bpa_pkg.sv -----
// Shared types and codes for the bitmap page allocator.
package bpa_pkg;

  // Request codes.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bpa_op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ALLOCATED    = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_FREED        = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } bpa_status_t;

  // One request item.
  typedef struct packed {
    bpa_op_t     op;
    logic [31:0] free_address;
  } bpa_in_t;

  // One result item.
  typedef struct packed {
    logic [31:0] block_address;
    bpa_status_t status;
  } bpa_out_t;

endpackage

// ----- rtl/bpa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bpa_cdiv.sv -----
// Division by a fixed power-of-two divisor as a registered shift and mask.
module bpa_cdiv #(
  parameter int DW      = 32,
  parameter int DIVISOR = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  output logic                        done,
  output logic [DW-1:0]               quot,
  output logic [$clog2(DIVISOR)-1:0]  rem
);

  localparam int RW = $clog2(DIVISOR);

  logic            done_r, done_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;

  // The quotient is the dividend shifted down, the remainder its low bits.
  always_comb begin
    done_nxt = start;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      quo_nxt = dividend >> RW;
      rem_nxt = dividend[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/bitmap_page_allocator.sv -----
// First-fit bitmap allocator of fixed-size physical memory blocks.
// Allocate: a first-fit scan of the bitmap RAM, which is read one word per cycle.
// Free, power-of-two sizes: two divides, then a word read and write unless never written.
// One request is in work at a time; a finished result waits in the output register.
// Reset: synchronous, active low; a high-water mark of written words makes the whole
// bitmap read as free right away, so no clearing pass runs and requests are taken at once.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int BLOCK_COUNT = 4096,
  parameter int BLOCK_BYTES = 4096,
  parameter int WORD_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  bpa_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output bpa_out_t    out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int MAP_WORDS = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(MAP_WORDS + 1);
  localparam int IDX_W     = $clog2(BLOCK_COUNT);
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LAST_BITS = BLOCK_COUNT - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] FULL_MASK = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] LAST_MASK = FULL_MASK >> (WORD_BITS - LAST_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SET,
    S_MUL,
    S_ADD,
    S_FDIV1,
    S_FDIV2,
    S_FRD,
    S_FWR,
    S_DONE
  } state_t;

  // Index of the lowest clear bit among the valid bits of a word.
  function automatic logic [BW-1:0] first_clear(input logic [WORD_BITS-1:0] word,
                                                 input logic [WORD_BITS-1:0] mask);
    logic [WORD_BITS-1:0] inv;
    logic [WORD_BITS-1:0] low;
    logic [BW-1:0]        pos;
    inv = ~word & mask;
    low = inv & (~inv + WORD_BITS'(1));
    pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (low[b]) begin
        pos = pos | BW'(b);
      end
    end
    return pos;
  endfunction

  state_t               state_r, state_nxt;
  logic [31:0]          base_r, base_nxt;
  logic [CW-1:0]        hw_r, hw_nxt;
  logic [CW-1:0]        iss_r, iss_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pw_r, pw_nxt;
  logic [AW-1:0]        fw_r, fw_nxt;
  logic [BW-1:0]        fj_r, fj_nxt;
  logic [WORD_BITS-1:0] fword_r, fword_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [31:0]          prod_r, prod_nxt;
  bpa_out_t             res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bpa_out_t             out_data_r, out_data_nxt;

  logic                 in_xfer;
  logic                 slot_free;
  logic [WORD_BITS-1:0] word_mask;
  logic [WORD_BITS-1:0] word_cur;
  logic                 word_open;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic                 diva_start;
  logic                 diva_done;
  logic [31:0]          diva_quot;
  logic                 divb_start;
  logic                 divb_done;
  logic [IDX_W-1:0]     divb_quot;
  logic [BW-1:0]        divb_rem;

  // Bitmap storage, one word per entry.
  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Address offset to block index.
  bpa_cdiv #(
    .DW      (32),
    .DIVISOR (BLOCK_BYTES)
  ) u_div_blk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (diva_start),
    .dividend (in_data.free_address - base_r),
    .done     (diva_done),
    .quot     (diva_quot),
    .rem      ()
  );

  // Block index to bitmap word and bit.
  bpa_cdiv #(
    .DW      (IDX_W),
    .DIVISOR (WORD_BITS)
  ) u_div_word (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (divb_start),
    .dividend (diva_quot[IDX_W-1:0]),
    .done     (divb_done),
    .quot     (divb_quot),
    .rem      (divb_rem)
  );

  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Word returned by the scan read; words at or past the high-water mark are free.
  assign word_mask = (pw_r == AW'(MAP_WORDS - 1)) ? LAST_MASK : FULL_MASK;
  assign word_cur  = ((CW'(pw_r) < hw_r) ? mem_rdata : '0) & word_mask;
  assign word_open = (word_cur != word_mask);

  assign diva_start = (state_r == S_IDLE) && in_xfer && (in_data.op == OP_FREE);
  assign divb_start = (state_r == S_FDIV1) && diva_done &&
                      (diva_quot < 32'(BLOCK_COUNT));

  // Bitmap read and write ports.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = fw_r;
    mem_we    = 1'b0;
    mem_waddr = fw_r;
    mem_wdata = fword_r | (WORD_BITS'(1) << fj_r);
    unique case (state_r)
      S_SCAN: begin
        mem_re    = (iss_r < CW'(MAP_WORDS)) && !(pend_r && word_open);
        mem_raddr = iss_r[AW-1:0];
      end
      S_FRD: begin
        mem_re = 1'b1;
      end
      S_SET: begin
        mem_we = 1'b1;
      end
      S_FWR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & ~(WORD_BITS'(1) << fj_r);
      end
      default: begin
      end
    endcase
  end

  // Sequencer for allocate and free requests.
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = cfg_we ? cfg_wdata : base_r;
    hw_nxt        = hw_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    pw_nxt        = pw_r;
    fw_nxt        = fw_r;
    fj_nxt        = fj_r;
    fword_nxt     = fword_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.op == OP_ALLOC) begin
            state_nxt = S_SCAN;
            iss_nxt   = '0;
            pend_nxt  = 1'b0;
          end else begin
            state_nxt = S_FDIV1;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && word_open) begin
          fw_nxt    = pw_r;
          fj_nxt    = first_clear(word_cur, word_mask);
          fword_nxt = word_cur;
          pend_nxt  = 1'b0;
          state_nxt = S_SET;
        end else if (iss_r < CW'(MAP_WORDS)) begin
          pend_nxt = 1'b1;
          pw_nxt   = iss_r[AW-1:0];
          iss_nxt  = iss_r + CW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          res_nxt.block_address = '0;
          res_nxt.status        = ST_NO_FREE;
          state_nxt             = S_DONE;
        end
      end
      S_SET: begin
        if (CW'(fw_r) >= hw_r) begin
          hw_nxt = CW'(fw_r) + CW'(1);
        end
        idx_nxt   = IDX_W'(32'(fw_r) * 32'(WORD_BITS) + 32'(fj_r));
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = 32'(idx_r) * 32'(BLOCK_BYTES);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        res_nxt.block_address = base_r + prod_r;
        res_nxt.status        = ST_ALLOCATED;
        state_nxt             = S_DONE;
      end
      S_FDIV1: begin
        if (diva_done) begin
          if (divb_start) begin
            state_nxt = S_FDIV2;
          end else begin
            res_nxt.block_address = '0;
            res_nxt.status        = ST_OUT_OF_RANGE;
            state_nxt             = S_DONE;
          end
        end
      end
      S_FDIV2: begin
        if (divb_done) begin
          fw_nxt = AW'(divb_quot);
          fj_nxt = divb_rem;
          res_nxt.block_address = '0;
          res_nxt.status        = ST_FREED;
          // A word never written is all free already.
          state_nxt = (CW'(divb_quot) < hw_r) ? S_FRD : S_DONE;
        end
      end
      S_FRD: begin
        state_nxt = S_FWR;
      end
      S_FWR: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      hw_r        <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      hw_r        <= hw_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pw_r       <= pw_nxt;
    fw_r       <= fw_nxt;
    fj_r       <= fj_nxt;
    fword_r    <= fword_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/bpa_checker.sv -----
// Port-level checks for the bitmap page allocator, bound to its top level.
module bpa_checker
  import bpa_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input bpa_out_t out_data
);

  // A held result keeps its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only a successful allocation carries an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_ALLOCATED) |-> (out_data.block_address == 32'd0))
    else $error("nonzero address without an allocation");

  // A request in work blocks the next one.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in work");

  // A new result appears only after a request was in work.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in work");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- sim/tb.sv -----
// Self-checking testbench for the first-fit bitmap page allocator.
module tb;
  import bpa_pkg::*;

  localparam int BLK_COUNT = 4096;
  localparam int BLK_BYTES = 4096;
  localparam int WBITS     = 32;
  localparam int MAP_WORDS = (BLK_COUNT + WBITS - 1) / WBITS;
  localparam int LONG_HOLD = 300;

  // Tracks the block map and the results that the allocator still owes.
  class alloc_scoreboard;
    logic [31:0]      base_addr;
    logic [WBITS-1:0] usage_map [MAP_WORDS];
    int               in_use;
    bpa_out_t         expected_q [$];
    int               errors;
    int               n_alloc;
    int               n_full;
    int               n_freed;
    int               n_range;

    function new();
      base_addr = '0;
      in_use    = 0;
      errors    = 0;
      n_alloc   = 0;
      n_full    = 0;
      n_freed   = 0;
      n_range   = 0;
      foreach (usage_map[w]) usage_map[w] = '0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Works out the result of one accepted request and updates the map.
    function void note_request(bpa_in_t req);
      bpa_out_t    exp;
      logic [31:0] diff;
      int unsigned idx;
      int          j;
      bit          done;
      exp.block_address = '0;
      done = 1'b0;
      if (req.op == OP_ALLOC) begin
        exp.status = ST_NO_FREE;
        // First word that is not full, lowest clear bit in it.
        for (int w = 0; w < MAP_WORDS && !done; w++) begin
          if (usage_map[w] != '1) begin
            j = 0;
            while (usage_map[w][j]) j++;
            usage_map[w][j] = 1'b1;
            in_use++;
            idx = w * WBITS + j;
            exp.block_address = base_addr + 32'(idx * BLK_BYTES);
            exp.status = ST_ALLOCATED;
            done = 1'b1;
          end
        end
      end else begin
        // The offset wraps modulo 2^32, so addresses below base land far out of range.
        diff = req.free_address - base_addr;
        idx = diff / BLK_BYTES;
        if (idx >= BLK_COUNT) begin
          exp.status = ST_OUT_OF_RANGE;
        end else begin
          if (usage_map[idx / WBITS][idx % WBITS]) in_use--;
          usage_map[idx / WBITS][idx % WBITS] = 1'b0;
          exp.status = ST_FREED;
        end
      end
      expected_q.push_back(exp);
    endfunction

    // Compares one result transfer with the oldest expectation.
    task check_result(bpa_out_t got);
      bpa_out_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: address %h status %0d",
                                  got.block_address, got.status));
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.block_address !== exp.block_address)
        report_mismatch($sformatf("block address %h, expected %h",
                                  got.block_address, exp.block_address));
      case (exp.status)
        ST_ALLOCATED:    n_alloc++;
        ST_NO_FREE:      n_full++;
        ST_FREED:        n_freed++;
        ST_OUT_OF_RANGE: n_range++;
        default:         ;
      endcase
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  bpa_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  bpa_out_t    out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  bit idle_en;
  bit hold_req;

  alloc_scoreboard sb = new();

  bitmap_page_allocator #(
    .BLOCK_COUNT(BLK_COUNT),
    .BLOCK_BYTES(BLK_BYTES),
    .WORD_BITS  (WBITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Clock with a period of two time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 5);
        out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Every accepted result transfer is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Offers one request, after an optional idle burst, and waits for its transfer.
  task automatic send_req(input bpa_in_t req);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic send_alloc(input logic [31:0] junk);
    bpa_in_t req;
    req.op = OP_ALLOC;
    req.free_address = junk;
    send_req(req);
  endtask

  task automatic send_free(input logic [31:0] addr);
    bpa_in_t req;
    req.op = OP_FREE;
    req.free_address = addr;
    send_req(req);
  endtask

  // Drops valid after the last transfer and waits until every result is back.
  task automatic finish_phase();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.base_addr = value;
  endtask

  // Random request: frees mostly hit the managed range, some fall below or past it.
  function automatic bpa_in_t rand_request(input int alloc_pct);
    bpa_in_t     r;
    int unsigned idx;
    int          hi;
    int          kind;
    r.free_address = $urandom();
    if ($urandom_range(1, 100) <= alloc_pct) begin
      r.op = OP_ALLOC;
      return r;
    end
    r.op = OP_FREE;
    kind = $urandom_range(0, 9);
    hi = sb.in_use + 8;
    if (hi > BLK_COUNT - 1) hi = BLK_COUNT - 1;
    if (kind < 7) begin
      idx = $urandom_range(0, 1) ? $urandom_range(0, BLK_COUNT - 1) : $urandom_range(0, hi);
      r.free_address = sb.base_addr + 32'(idx * BLK_BYTES);
      if ($urandom_range(0, 1))
        r.free_address = r.free_address + 32'($urandom_range(0, BLK_BYTES - 1));
    end else if (kind == 7) begin
      r.free_address = sb.base_addr - 32'($urandom_range(1, 2 * BLK_BYTES));
    end else if (kind == 8) begin
      r.free_address = sb.base_addr + 32'(BLK_COUNT * BLK_BYTES)
                       + 32'($urandom_range(0, 3 * BLK_BYTES));
    end
    return r;
  endfunction

  task automatic run_random(input int count, input int alloc_pct);
    for (int i = 0; i < count; i++) send_req(rand_request(alloc_pct));
    finish_phase();
  endtask

  // Main sequence.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_en   = 1'b1;
    hold_req  = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed requests at the reset base of zero.
    send_alloc(32'h0);
    send_alloc(32'hFFFF_FFFF);
    send_alloc(32'h0);
    send_free(32'h0000_1000);
    send_alloc(32'h0);
    send_free(32'h0000_2FFF);    // unaligned, frees the block holding it
    send_free(32'h0000_2000);    // already free
    send_alloc(32'h0);
    send_free(32'h00FF_F000);    // last managed block
    send_free(32'h0100_0000);    // one block past the end
    send_free(32'hFFFF_FFFF);
    send_alloc(32'hFFFF_FFFF);
    finish_phase();

    // Highest aligned base, so block addresses wrap past zero.
    write_base(32'hFFFF_F000);
    send_alloc(32'h0);
    send_alloc(32'h0);
    send_free(32'h0000_2000);
    send_free(32'hFFFF_E000);    // just below the base
    send_free(32'hFFFF_F000);
    send_alloc(32'h0);
    finish_phase();

    // Random mix at a random aligned base, with one long hold on results.
    write_base($urandom() & 32'hFFFF_F000);
    hold_req = 1'b1;
    run_random(150, 60);

    // A few allocations at an all-ones base.
    write_base(32'hFFFF_FFFF);
    repeat (3) send_alloc($urandom());
    finish_phase();

    // Churn on a partly used map.
    write_base($urandom() & 32'hFFFF_F000);
    run_random(220, 50);

    // Last stretch without any idling.
    idle_en = 1'b0;
    write_base(32'h0);
    run_random(40, 50);

    repeat (20) @(posedge clk);
    $display("Checked %0d allocations, %0d refusals on a full map, %0d frees, %0d rejected frees.",
             sb.n_alloc, sb.n_full, sb.n_freed, sb.n_range);
    $display("Bases covered zero, the top aligned page, all ones and random aligned values.");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_cdiv.sv
rtl/bitmap_page_allocator.sv
rtl/bpa_checker.sv
sim/tb.sv
